// File: rtl/core/wst_pkg.sv
package wst_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 40;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // header constants
    localparam logic [11:0] MIN_HEADER_LEN  = 12'd24;
    localparam logic [1:0]  FTYPE_MGMT      = 2'h0;
    localparam logic [1:0]  FTYPE_DATA      = 2'h2;
    localparam logic [3:0]  SUB_ASSOC_REQ   = 4'h0;
    localparam logic [3:0]  SUB_REASSOC_REQ = 4'h2;
    localparam logic [3:0]  SUB_PROBE_RSP   = 4'h5;
    localparam logic [3:0]  SUB_DISASSOC    = 4'hA;
    localparam logic [3:0]  SUB_AUTH        = 4'hB;
    localparam logic [3:0]  SUB_DEAUTH      = 4'hC;
    localparam logic [31:0] DEFAULT_TIMEOUT = 32'd25000;

    // register map (index = paddr[4:3])
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_BSSID   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_PURGE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_IGNORED   = 3'd0,
        STAT_REFRESHED = 3'd1,
        STAT_INSERTED  = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_PURGED    = 3'd4,
        STAT_READ      = 3'd5,
        STAT_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [47:0]       mac;
        logic [31:0]       seen;
        logic signed [7:0] rssi;
    } entry_t;

    typedef struct packed {
        logic        enable;
        logic [47:0] bssid;
        logic [31:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac;
    } class_t;

endpackage

// File: rtl/core/wlan_station_tracker.sv
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tuser: req_type; tdata: request fields
// m_axis   | out | m_axis_tvalid/tready   | tuser: status; tdata: count and entry
// apb      | in  | psel/penable, pready=1 | enable, target_bssid, timeout_ms
//
// One request at a time; s_axis_tready is high only when idle.
// Table lives in a single-port-write, registered-read RAM swept slot by slot (ST_RD, then ST_CMP):
// frame and purge sweep up to the client count, read visits at most one slot, clear sweeps none.
// Reset empties the table by clearing the count; no clearing pass.
// A result waits in the output register until taken; the block stalls only there.
module wlan_station_tracker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [11:0] frame_len, [27:12] frame_control, [75:28] addr_one, [123:76] addr_two,
    // [171:124] addr_three, [179:172] signal_dbm, [211:180] now_ms,
    // [217:212] read_index, rest zero
    input  logic [223:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [5:0] client_count, [6] entry_valid, [54:7] entry_mac, [62:55] entry_rssi,
    // [94:63] entry_last_seen, [95] zero
    output logic [95:0]  m_axis_tdata,
    // [2:0] status
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import wst_pkg::*;

    cfg_t   cfg;
    class_t cls;

    logic [11:0]       in_len;
    logic [15:0]       in_fc;
    logic [47:0]       in_a1;
    logic [47:0]       in_a2;
    logic [47:0]       in_a3;
    logic signed [7:0] in_sig;
    logic [31:0]       in_now;
    logic [5:0]        in_idx;

    assign in_len = s_axis_tdata[11:0];
    assign in_fc  = s_axis_tdata[27:12];
    assign in_a1  = s_axis_tdata[75:28];
    assign in_a2  = s_axis_tdata[123:76];
    assign in_a3  = s_axis_tdata[171:124];
    assign in_sig = s_axis_tdata[179:172];
    assign in_now = s_axis_tdata[211:180];
    assign in_idx = s_axis_tdata[217:212];

    wst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wst_classify u_cls (
        .cfg           (cfg),
        .frame_len     (in_len),
        .frame_control (in_fc),
        .addr_one      (in_a1),
        .addr_two      (in_a2),
        .addr_three    (in_a3),
        .cls           (cls)
    );

    // table RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;

    wst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer state
    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [47:0]       mac_reg, mac_next;
    logic signed [7:0] rssi_reg, rssi_next;
    logic [31:0]       now_reg, now_next;
    status_t           status_reg, status_next;
    logic              ev_reg, ev_next;
    entry_t            ent_reg, ent_next;

    // output word
    logic              mv_reg, mv_next;
    status_t           ms_reg, ms_next;
    logic [5:0]        mc_reg, mc_next;
    logic              mev_reg, mev_next;
    entry_t            ment_reg, ment_next;

    logic              accept;
    logic              read_ok;
    logic [31:0]       age;
    logic              out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign read_ok  = 32'(in_idx) < 32'(count_reg);
    assign age      = now_reg - ram_rdata.seen;
    assign out_free = !mv_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        kept_reg   <= kept_next;
        mac_reg    <= mac_next;
        rssi_reg   <= rssi_next;
        now_reg    <= now_next;
        status_reg <= status_next;
        ev_reg     <= ev_next;
        ent_reg    <= ent_next;
        ms_reg     <= ms_next;
        mc_reg     <= mc_next;
        mev_reg    <= mev_next;
        ment_reg   <= ment_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        kept_next   = kept_reg;
        count_next  = count_reg;
        mac_next    = mac_reg;
        rssi_next   = rssi_reg;
        now_next    = now_reg;
        status_next = status_reg;
        ev_next     = ev_reg;
        ent_next    = ent_reg;
        ms_next     = ms_reg;
        mc_next     = mc_reg;
        mev_next    = mev_reg;
        ment_next   = ment_reg;
        mv_next     = mv_reg && !m_axis_tready;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[ADDR_W-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg[ADDR_W-1:0];
        s_axis_tready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op_t'(s_axis_tuser);
                    mac_next  = cls.mac;
                    rssi_next = in_sig;
                    now_next  = in_now;
                    idx_next  = '0;
                    kept_next = '0;
                    ev_next   = 1'b0;
                    ent_next  = '0;
                    unique case (op_t'(s_axis_tuser))
                        OP_FRAME:
                        begin
                            status_next = STAT_IGNORED;
                            state_next  = cls.hit ? ST_RD : ST_DONE;
                        end
                        OP_PURGE:
                        begin
                            state_next = ST_RD;
                        end
                        OP_READ:
                        begin
                            status_next = STAT_READ;
                            idx_next    = CNT_W'(in_idx);
                            state_next  = read_ok ? ST_RD : ST_DONE;
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            status_next = STAT_CLEARED;
                            state_next  = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // issue a read, or at the end of the sweep insert if room (frame) or set the kept count (purge) and finish
            ST_RD:
            begin
                unique case (op_reg)
                    OP_FRAME:
                    begin
                        if (idx_reg == count_reg)
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[ADDR_W-1:0];
                                ram_wdata   = '{mac: mac_reg, seen: now_reg, rssi: rssi_reg};
                                count_next  = count_reg + 1'b1;
                                status_next = STAT_INSERTED;
                            end
                            else
                            begin
                                status_next = STAT_FULL;
                            end
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_CMP;
                        end
                    end
                    OP_PURGE:
                    begin
                        if (idx_reg == count_reg)
                        begin
                            count_next  = kept_reg;
                            status_next = STAT_PURGED;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_CMP;
                        end
                    end
                    OP_READ:
                    begin
                        state_next = ST_CMP;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // compare the entry just read, or capture it for a read request
            ST_CMP:
            begin
                unique case (op_reg)
                    OP_FRAME:
                    begin
                        if (ram_rdata.mac == mac_reg)
                        begin
                            ram_we         = 1'b1;
                            ram_wdata.seen = now_reg;
                            if (rssi_reg != 8'sd0)
                            begin
                                ram_wdata.rssi = rssi_reg;
                            end
                            status_next = STAT_REFRESHED;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_RD;
                        end
                    end
                    OP_PURGE:
                    begin
                        if (age < cfg.timeout)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = kept_reg[ADDR_W-1:0];
                            kept_next = kept_reg + 1'b1;
                        end
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                    OP_READ:
                    begin
                        ev_next    = 1'b1;
                        ent_next   = ram_rdata;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    ms_next    = status_reg;
                    mc_next    = 6'(count_reg);
                    mev_next   = ev_reg;
                    ment_next  = ent_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tuser  = ms_reg;
    assign m_axis_tdata  = {1'b0, ment_reg.seen, ment_reg.rssi, ment_reg.mac, mev_reg, mc_reg};

endmodule

// File: rtl/core/wst_ram.sv
module wst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/wst_cfg.sv
module wst_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output wst_pkg::cfg_t     cfg
);
    import wst_pkg::*;

    logic        enable_reg;
    logic [47:0] bssid_reg;
    logic [31:0] timeout_reg;
    logic [1:0]  reg_idx;
    logic        wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr      = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            bssid_reg   <= '0;
            timeout_reg <= DEFAULT_TIMEOUT;
        end
        else if (wr)
        begin
            if (reg_idx == REG_ENABLE)  enable_reg  <= pwdata[0];
            if (reg_idx == REG_BSSID)   bssid_reg   <= pwdata[47:0];
            if (reg_idx == REG_TIMEOUT) timeout_reg <= pwdata[31:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_ENABLE:  prdata = {63'd0, enable_reg};
            REG_BSSID:   prdata = {16'd0, bssid_reg};
            REG_TIMEOUT: prdata = {32'd0, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg = '{enable: enable_reg, bssid: bssid_reg, timeout: timeout_reg};

endmodule

// File: rtl/core/wst_classify.sv
module wst_classify (
    input  wst_pkg::cfg_t   cfg,
    input  logic [11:0]     frame_len,
    input  logic [15:0]     frame_control,
    input  logic [47:0]     addr_one,
    input  logic [47:0]     addr_two,
    input  logic [47:0]     addr_three,
    output wst_pkg::class_t cls
);
    import wst_pkg::*;

    logic [1:0]  ftype;
    logic [3:0]  sub;
    logic        to_ds;
    logic        from_ds;
    logic        sub_ok;
    logic        named;
    logic [47:0] sta;

    assign ftype   = frame_control[3:2];
    assign sub     = frame_control[7:4];
    assign to_ds   = frame_control[8];
    assign from_ds = frame_control[9];
    assign sub_ok  = (sub == SUB_ASSOC_REQ) || (sub == SUB_REASSOC_REQ)
                  || (sub == SUB_AUTH) || (sub == SUB_PROBE_RSP)
                  || (sub == SUB_DISASSOC) || (sub == SUB_DEAUTH);

    // pick the station address named by the header, if any
    always_comb
    begin
        named = 1'b0;
        sta   = addr_two;
        if (ftype == FTYPE_DATA)
        begin
            if (to_ds && !from_ds && addr_one == cfg.bssid)
            begin
                named = 1'b1;
                sta   = addr_two;
            end
            else if (!to_ds && from_ds && addr_two == cfg.bssid)
            begin
                named = 1'b1;
                sta   = addr_one;
            end
        end
        else if (ftype == FTYPE_MGMT && addr_three == cfg.bssid && sub_ok
                 && addr_two != cfg.bssid)
        begin
            named = 1'b1;
        end
    end

    // non-null unicast only
    assign cls.hit = cfg.enable && (frame_len >= MIN_HEADER_LEN) && named
                  && (sta != 48'd0) && !sta[40];
    assign cls.mac = sta;

endmodule

// File: test/tb_wlan_station_tracker.sv
module tb_wlan_station_tracker;
    import wst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 2000000;

    // one request word as the block sees it
    typedef struct {
        op_t               op;
        logic [11:0]       len;
        logic [15:0]       fc;
        logic [47:0]       a1;
        logic [47:0]       a2;
        logic [47:0]       a3;
        logic signed [7:0] dbm;
        logic [31:0]       now;
        logic [5:0]        idx;
    } req_t;

    // one result word
    typedef struct {
        status_t           stat;
        logic [5:0]        count;
        logic              valid;
        logic [47:0]       mac;
        logic signed [7:0] rssi;
        logic [31:0]       seen;
    } rsp_t;

    // directed row: request plus an optional hand-typed result
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    wlan_station_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // tracker shadow state
    logic              sh_enable;
    logic [47:0]       sh_bssid;
    logic [31:0]       sh_timeout;
    logic [47:0]       sh_mac  [TABLE_DEPTH];
    logic [31:0]       sh_seen [TABLE_DEPTH];
    logic signed [7:0] sh_rssi [TABLE_DEPTH];
    int                sh_count;

    rsp_t pending_rsp[$];
    int   n_errors;
    int   cycle_count;
    bit   hold_off;
    bit   stim_done;

    // sender-side pool of plausible stations
    logic [47:0] sta_pool[16];
    logic [47:0] bssid_pool[3];

    function automatic status_t track_station(logic [47:0] mac, logic signed [7:0] dbm,
                                              logic [31:0] now);
        if (mac == 48'd0 || mac[40])
            return STAT_IGNORED;
        for (int i = 0; i < sh_count; i++)
        begin
            if (sh_mac[i] == mac)
            begin
                sh_seen[i] = now;
                if (dbm != 8'sd0)
                    sh_rssi[i] = dbm;
                return STAT_REFRESHED;
            end
        end
        if (sh_count < TABLE_DEPTH)
        begin
            sh_mac[sh_count]  = mac;
            sh_seen[sh_count] = now;
            sh_rssi[sh_count] = dbm;
            sh_count++;
            return STAT_INSERTED;
        end
        return STAT_FULL;
    endfunction

    function automatic status_t classify_frame(req_t r);
        logic [1:0] ftype;
        logic [3:0] sub;
        logic       to_ds;
        logic       from_ds;
        ftype   = r.fc[3:2];
        sub     = r.fc[7:4];
        to_ds   = r.fc[8];
        from_ds = r.fc[9];
        if (!sh_enable || r.len < MIN_HEADER_LEN)
            return STAT_IGNORED;
        if (ftype == FTYPE_DATA)
        begin
            if (to_ds && !from_ds && r.a1 == sh_bssid)
                return track_station(r.a2, r.dbm, r.now);
            if (!to_ds && from_ds && r.a2 == sh_bssid)
                return track_station(r.a1, r.dbm, r.now);
            return STAT_IGNORED;
        end
        if (ftype == FTYPE_MGMT && r.a3 == sh_bssid && r.a2 != sh_bssid &&
            (sub == SUB_ASSOC_REQ || sub == SUB_REASSOC_REQ || sub == SUB_AUTH ||
             sub == SUB_PROBE_RSP || sub == SUB_DISASSOC || sub == SUB_DEAUTH))
            return track_station(r.a2, r.dbm, r.now);
        return STAT_IGNORED;
    endfunction

    // expected result of one request, updating the shadow table
    function automatic rsp_t predict_tracker(req_t r);
        rsp_t o;
        int   kept;
        o = '{STAT_IGNORED, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0};
        case (r.op)
            OP_FRAME: o.stat = classify_frame(r);
            OP_PURGE:
            begin
                kept = 0;
                for (int i = 0; i < sh_count; i++)
                begin
                    if (32'(r.now - sh_seen[i]) < sh_timeout)
                    begin
                        sh_mac[kept]  = sh_mac[i];
                        sh_seen[kept] = sh_seen[i];
                        sh_rssi[kept] = sh_rssi[i];
                        kept++;
                    end
                end
                sh_count = kept;
                o.stat = STAT_PURGED;
            end
            OP_READ:
            begin
                o.stat = STAT_READ;
                if (int'(r.idx) < sh_count)
                begin
                    o.valid = 1'b1;
                    o.mac   = sh_mac[r.idx];
                    o.rssi  = sh_rssi[r.idx];
                    o.seen  = sh_seen[r.idx];
                end
            end
            default:
            begin
                sh_count = 0;
                o.stat = STAT_CLEARED;
            end
        endcase
        o.count = 6'(sh_count);
        return o;
    endfunction

    function automatic req_t blank_req(op_t op);
        req_t r;
        r = '{op, 12'd0, 16'd0, 48'd0, 48'd0, 48'd0, 8'sd0, 32'd0, 6'd0};
        return r;
    endfunction

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom(), $urandom()});
    endfunction

    // mostly well-formed frames around the target, some reads, purges and clears, the rest noise
    function automatic req_t random_req(logic [31:0] now);
        req_t        r;
        int          pick;
        logic [47:0] sta;
        logic [3:0]  subs[6];
        subs = '{SUB_ASSOC_REQ, SUB_REASSOC_REQ, SUB_PROBE_RSP, SUB_DISASSOC,
                 SUB_AUTH, SUB_DEAUTH};
        r = blank_req(OP_FRAME);
        r.len = 12'($urandom_range(24, 1500));
        r.dbm = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            r.dbm = 8'sd0;
        r.now = now;
        r.idx = 6'($urandom_range(0, 63));
        sta = sta_pool[$urandom_range(0, 15)];
        if ($urandom_range(0, 9) == 0)
            sta = rand_mac();
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.fc = 16'h0108 | 16'($urandom_range(0, 15) << 4) | 16'($urandom() & 16'hFC00);
            r.a1 = sh_bssid;
            r.a2 = sta;
            r.a3 = rand_mac();
        end
        else if (pick < 50)
        begin
            r.fc = 16'h0208 | 16'($urandom() & 16'hFCF0);
            r.a1 = sta;
            r.a2 = sh_bssid;
            r.a3 = rand_mac();
        end
        else if (pick < 68)
        begin
            r.fc = 16'({subs[$urandom_range(0, 5)], 4'h0}) | 16'($urandom() & 16'hFF03);
            r.a1 = sh_bssid;
            r.a2 = sta;
            r.a3 = sh_bssid;
        end
        else if (pick < 76)
        begin
            r.op  = OP_READ;
            r.idx = 6'($urandom_range(0, 44));
            if ($urandom_range(0, 9) == 0)
                r.idx = 6'($urandom_range(0, 63));
        end
        else if (pick < 80)
            r.op = OP_PURGE;
        else if (pick < 81)
            r.op = OP_CLEAR;
        else
        begin
            // raw noise over the whole field space
            r.op  = op_t'($urandom_range(0, 3));
            if (r.op == OP_CLEAR)
                r.op = OP_FRAME;
            r.len = 12'($urandom_range(0, 4095));
            r.fc  = 16'($urandom());
            r.a1  = ($urandom_range(0, 1) != 0) ? sh_bssid : rand_mac();
            r.a2  = ($urandom_range(0, 3) == 0) ? sh_bssid : rand_mac();
            r.a3  = ($urandom_range(0, 1) != 0) ? sh_bssid : rand_mac();
            r.idx = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0)
                r.now = $urandom();
        end
        return r;
    endfunction

    // short or long gap, now and then none
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_word(req_t r);
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {6'd0, r.idx, r.now, r.dbm, r.a3, r.a2, r.a1, r.fc, r.len};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_rsp.push_back(predict_tracker(r));
    endtask

    // sometimes drop valid, then wait out a random gap
    task automatic drop_and_gap();
        if ($urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            random_gap();
        end
    endtask

    task automatic send_and_gap(req_t r);
        send_word(r);
        drop_and_gap();
    endtask

    // directed row: a typed result replaces the predicted one
    task automatic send_row(row_t row);
        send_word(row.req);
        if (row.typed)
            pending_rsp[pending_rsp.size() - 1] = row.rsp;
        drop_and_gap();
    endtask

    task automatic apb_write(logic [1:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:  sh_enable  = val[0];
            REG_BSSID:   sh_bssid   = val[47:0];
            REG_TIMEOUT: sh_timeout = val[31:0];
            default: ;
        endcase
    endtask

    // let the block drain before a register write
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_DEPTH + 10) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result word with nothing expected: status %0d", m_axis_tuser);
                n_errors++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (m_axis_tuser != exp_rsp.stat)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.stat, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata[5:0] != exp_rsp.count)
                begin
                    $error("client_count: expected %0d, got %0d", exp_rsp.count,
                           m_axis_tdata[5:0]);
                    n_errors++;
                end
                if (m_axis_tdata[6] != exp_rsp.valid)
                begin
                    $error("entry_valid: expected %0d, got %0d", exp_rsp.valid,
                           m_axis_tdata[6]);
                    n_errors++;
                end
                if (m_axis_tdata[54:7] != exp_rsp.mac)
                begin
                    $error("entry_mac: expected %h, got %h", exp_rsp.mac, m_axis_tdata[54:7]);
                    n_errors++;
                end
                if (m_axis_tdata[62:55] != exp_rsp.rssi)
                begin
                    $error("entry_rssi: expected %0d, got %0d", exp_rsp.rssi,
                           $signed(m_axis_tdata[62:55]));
                    n_errors++;
                end
                if (m_axis_tdata[94:63] != exp_rsp.seen)
                begin
                    $error("entry_last_seen: expected %0d, got %0d", exp_rsp.seen,
                           m_axis_tdata[94:63]);
                    n_errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off)
            m_axis_tready <= 1'b0;
        else if (stim_done || cycle_count % 3000 < 600)
            m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 29) == 0)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 2) == 0)
            m_axis_tready <= ~m_axis_tready;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_wlan_station_tracker: errors");
            $finish;
        end
    end

    initial
    begin
        row_t        rows[$];
        row_t        row;
        req_t        r;
        rsp_t        got;
        logic [31:0] clock_ms;
        int          phase;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        n_errors      = 0;
        cycle_count   = 0;
        hold_off      = 1'b0;
        stim_done     = 1'b0;
        sh_enable     = 1'b0;
        sh_bssid      = 48'd0;
        sh_timeout    = DEFAULT_TIMEOUT;
        sh_count      = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sh_mac[i]  = '0;
            sh_seen[i] = '0;
            sh_rssi[i] = '0;
        end
        for (int i = 0; i < 16; i++)
            sta_pool[i] = {8'h02 + 8'(4 * i), 8'(i), $urandom()};
        sta_pool[15] = 48'hFFFF_FFFF_FFFF;
        bssid_pool = '{48'h00_11_22_33_44_55, 48'hFE_FF_FF_FF_FF_FF, 48'h0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, disabled, then enabled cases
        got = '{STAT_IGNORED, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0};
        r = blank_req(OP_READ);
        r.idx = 6'd63;
        got.stat = STAT_READ;
        rows.push_back('{r, 1'b1, got});
        r = blank_req(OP_FRAME);
        r.len = 12'hFFF;
        r.fc  = 16'h0108;
        r.a2  = 48'h02_00_00_00_00_01;
        got.stat = STAT_IGNORED;
        rows.push_back('{r, 1'b1, got});
        r = blank_req(OP_PURGE);
        r.now = 32'hFFFF_FFFF;
        got.stat = STAT_PURGED;
        rows.push_back('{r, 1'b1, got});
        r = blank_req(OP_CLEAR);
        got.stat = STAT_CLEARED;
        rows.push_back('{r, 1'b1, got});
        foreach (rows[i])
            send_row(rows[i]);
        wait_idle();
        rows.delete();

        apb_write(REG_ENABLE, 64'd1);
        apb_write(REG_BSSID, 64'hFFFF_0011_2233_4455);
        apb_write(REG_TIMEOUT, 64'hFFFF_FFFF_FFFF_FFFF);

        // data to-DS: insert with zero strength, then refresh keeps it
        r = blank_req(OP_FRAME);
        r.len = 12'd24;
        r.fc  = 16'h0108;
        r.a1  = 48'h00_11_22_33_44_55;
        r.a2  = 48'hFC_FF_FF_FF_FF_FF;
        r.now = 32'd100;
        rows.push_back('{r, 1'b0, got});
        r.dbm = -8'sd128;
        r.now = 32'hFFFF_FFFF;
        rows.push_back('{r, 1'b0, got});
        r.dbm = 8'sd0;
        rows.push_back('{r, 1'b0, got});
        r.len = 12'd23;
        rows.push_back('{r, 1'b0, got});
        // group and null stations
        r.len = 12'd24;
        r.a2  = 48'h01_00_5E_00_00_01;
        rows.push_back('{r, 1'b0, got});
        r.a2  = 48'd0;
        rows.push_back('{r, 1'b0, got});
        // from-DS, both DS bits, control type
        r = blank_req(OP_FRAME);
        r.len = 12'd60;
        r.fc  = 16'h0208;
        r.a1  = 48'h02_AA_BB_CC_DD_EE;
        r.a2  = 48'h00_11_22_33_44_55;
        r.dbm = 8'sd127;
        r.now = 32'd5;
        rows.push_back('{r, 1'b0, got});
        r.fc  = 16'h0308;
        rows.push_back('{r, 1'b0, got});
        r.fc  = 16'h0004;
        rows.push_back('{r, 1'b0, got});
        // management subtypes, listed and not, sender equal to target
        for (int s = 0; s < 16; s += 3)
        begin
            r = blank_req(OP_FRAME);
            r.len = 12'd30;
            r.fc  = 16'(s << 4);
            r.a2  = {8'h06, 8'(s), 32'h1234_5678};
            r.a3  = 48'h00_11_22_33_44_55;
            r.dbm = -8'sd40;
            r.now = 32'd7;
            rows.push_back('{r, 1'b0, got});
        end
        r.fc = 16'h00C0;
        r.a2 = 48'h00_11_22_33_44_55;
        rows.push_back('{r, 1'b0, got});
        r = blank_req(OP_READ);
        for (int k = 0; k < 3; k++)
        begin
            r.idx = 6'(k);
            rows.push_back('{r, 1'b0, got});
        end
        r = blank_req(OP_PURGE);
        r.now = 32'd50;
        rows.push_back('{r, 1'b0, got});
        foreach (rows[i])
        begin
            row = rows[i];
            send_row(row);
        end
        wait_idle();
        rows.delete();

        // timeout zero: purge empties the table
        apb_write(REG_TIMEOUT, 64'd0);
        r = blank_req(OP_PURGE);
        send_word(r);
        wait_idle();

        // random phases over several register settings
        clock_ms = 32'hFFFF_F000;
        for (phase = 0; phase < 6; phase++)
        begin
            apb_write(REG_BSSID, {16'd0, bssid_pool[phase % 3]});
            apb_write(REG_TIMEOUT, (phase == 5) ? 64'd1 :
                      (phase == 3) ? 64'hFFFF_FFFF : 64'($urandom_range(200, 4000)));
            apb_write(REG_ENABLE, (phase == 4) ? 64'd0 : 64'd1);
            if (phase == 2)
            begin
                // long receiver hold-off while requests keep coming
                hold_off = 1'b1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < RANDOM_WORDS / 6; n++)
            begin
                clock_ms += 32'($urandom_range(0, 60));
                r = random_req(clock_ms);
                send_and_gap(r);
            end
            wait_idle();
        end

        stim_done = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_DEPTH + 10) @(posedge clk);
        if (n_errors == 0)
            $display("tb_wlan_station_tracker: clean");
        else
            $display("tb_wlan_station_tracker: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/wst_pkg.sv
rtl/core/wst_ram.sv
rtl/core/wst_cfg.sv
rtl/core/wst_classify.sv
rtl/core/wlan_station_tracker.sv
test/tb_wlan_station_tracker.sv
